[sv/vha_pkg.sv]
// Package for the versioned handle allocator: field widths, codes, command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vha_pkg;
    localparam int TableEntries = 256;
    localparam int QueueDepth   = 512;
    localparam int VersionBits  = 16;
    localparam int IdW  = 9;
    localparam int VerW = 16;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_PROCESS = 2'd2,
        OP_CHECK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_INVALID = 3'd2,
        ST_QEMPTY  = 3'd3,
        ST_QFULL   = 3'd4,
        ST_STALE   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_FINAL     = 2'd1,
        EV_DESTROYED = 2'd2,
        EV_FAILED    = 2'd3
    } t_event;

    localparam logic KIND_CREATE  = 1'b0;
    localparam logic KIND_DESTROY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture request, issue slot/queue reads
        logic exec;   // evaluate with read data, update state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;
    } t_sts;
endpackage
`default_nettype wire

[sv/vha_ram.sv]
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module vha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[sv/vha_ctrl.sv]
// Controller: sequences load, execute and result hand-off.
// Depends on vha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_out_free,
    input  vha_pkg::t_sts      i_sts,
    output vha_pkg::t_cmd      o_cmd
);
    typedef enum logic [0:0] {S_IDLE, S_EXEC} t_state;
    t_state r_state;

    always_comb begin
        o_in_ready = (r_state == S_IDLE) && i_out_free;
        o_cmd.load = o_in_ready && i_in_valid;
        o_cmd.exec = (r_state == S_EXEC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (o_cmd.load) r_state <= S_EXEC;
                S_EXEC: if (i_sts.done) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/vha_dp.sv]
// Datapath: slot table, command queue, free list, counters and result register.
// Depends on vha_pkg and vha_ram.
`timescale 1ns / 1ps
`default_nettype none
module vha_dp #(
    parameter int TABLE_ENTRIES = vha_pkg::TableEntries,
    parameter int QUEUE_DEPTH   = vha_pkg::QueueDepth,
    parameter int VERSION_BITS  = vha_pkg::VersionBits
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  vha_pkg::t_cmd             i_cmd,
    output vha_pkg::t_sts             o_sts,
    input  wire logic [1:0]           i_op,
    input  wire logic [vha_pkg::IdW-1:0]  i_hid,
    input  wire logic [vha_pkg::VerW-1:0] i_hver,
    input  wire logic                 i_fin_ok,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [2:0]                o_status,
    output logic [vha_pkg::IdW-1:0]   o_id,
    output logic [vha_pkg::VerW-1:0]  o_ver,
    output logic [1:0]                o_ev,
    output logic                      o_valid,
    output logic [vha_pkg::IdW-1:0]   o_active
);
    localparam int SW = $clog2(TABLE_ENTRIES);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int VB = VERSION_BITS;
    localparam int CW = 1 + SW + VB;
    localparam int FW = 3;
    localparam logic [2:0] F_VALID = 3'b001, F_DESTROY = 3'b010, F_FINAL = 3'b100;

    // request capture
    logic [1:0]            r_op;
    logic [vha_pkg::IdW-1:0]  r_hid;
    logic [vha_pkg::VerW-1:0] r_hver;
    logic                  r_fin;

    // control state
    logic [SW:0]   r_in_use;
    logic [SW-1:0] r_fhead, r_ftail;
    logic          r_fempty;
    logic [QW-1:0] r_qhead;
    logic [QW:0]   r_qcount;
    logic [SW:0]   r_live;

    // memories
    logic [VB-1:0] ver_rd;
    logic [FW-1:0] flg_rd;
    logic [SW-1:0] nxt_rd;
    logic [CW-1:0] q_rd;
    logic [SW-1:0] slot_raddr;
    logic          ver_we, flg_we, nxt_we, q_we;
    logic [SW-1:0] ver_wa, flg_wa, nxt_wa;
    logic [VB-1:0] ver_wd;
    logic [FW-1:0] flg_wd;
    logic [SW-1:0] nxt_wd;
    logic [QW-1:0] q_wa;
    logic [CW-1:0] q_wd;

    // load-cycle address choice
    logic [SW-1:0] hidx_ld;
    assign hidx_ld = SW'(i_hid - 9'd1);
    always_comb begin
        unique case (vha_pkg::t_op'(i_op))
            vha_pkg::OP_CREATE:  slot_raddr = r_fhead;
            vha_pkg::OP_PROCESS: slot_raddr = SW'(0);
            default:             slot_raddr = hidx_ld;
        endcase
    end

    // process needs the queue entry first, then its slot; create uses free head.
    // The queue is read each cycle at head; the slot for a process request is read
    // from the queue data while r_phase is low and used once r_phase is set.
    logic r_phase;
    logic rd_cmd_slot;
    logic [SW-1:0] slot_ra_mux;
    assign rd_cmd_slot = i_cmd.exec && !r_phase
                      && vha_pkg::t_op'(r_op) == vha_pkg::OP_PROCESS;
    assign slot_ra_mux = rd_cmd_slot ? q_rd[VB +: SW] : slot_raddr;

    vha_ram #(.WIDTH(VB), .DEPTH(TABLE_ENTRIES)) u_ver (
        .i_clk, .i_we(ver_we), .i_waddr(ver_wa), .i_wdata(ver_wd),
        .i_raddr(slot_ra_mux), .o_rdata(ver_rd));
    vha_ram #(.WIDTH(FW), .DEPTH(TABLE_ENTRIES)) u_flg (
        .i_clk, .i_we(flg_we), .i_waddr(flg_wa), .i_wdata(flg_wd),
        .i_raddr(slot_ra_mux), .o_rdata(flg_rd));
    vha_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_nxt (
        .i_clk, .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(slot_ra_mux), .o_rdata(nxt_rd));
    vha_ram #(.WIDTH(CW), .DEPTH(QUEUE_DEPTH)) u_q (
        .i_clk, .i_we(q_we), .i_waddr(q_wa), .i_wdata(q_wd),
        .i_raddr(r_qhead), .o_rdata(q_rd));

    // execute
    logic          fire;
    logic          q_full;
    logic          live_ok;
    logic [SW-1:0] hidx;
    logic [SW-1:0] cidx;
    logic [VB-1:0] cver;
    logic          ckind;
    logic [QW-1:0] q_tail;
    logic [2:0]    n_status;
    logic [vha_pkg::IdW-1:0] n_id;
    logic [vha_pkg::VerW-1:0] n_ver;
    logic [1:0]    n_ev;
    logic          n_valid;
    logic          hold;

    assign fire   = i_cmd.exec && !(vha_pkg::t_op'(r_op) == vha_pkg::OP_PROCESS && !r_phase
                                    && r_qcount != '0);
    assign o_sts.done = fire;
    assign q_full = r_qcount >= (QW+1)'(QUEUE_DEPTH);
    assign hidx   = SW'(r_hid - 9'd1);
    assign q_tail = QW'(r_qhead + r_qcount[QW-1:0]);
    assign cidx   = q_rd[VB +: SW];
    assign cver   = q_rd[VB-1:0];
    assign ckind  = q_rd[CW-1];
    assign live_ok = (r_hid != '0) && ({1'b0, r_hid} <= 10'(r_in_use))
                  && (32'(r_hid) <= 32'(TABLE_ENTRIES))
                  && flg_rd[0] && !flg_rd[1] && (ver_rd == VB'(r_hver));

    always_comb begin
        ver_we = 1'b0; flg_we = 1'b0; nxt_we = 1'b0; q_we = 1'b0;
        ver_wa = cidx; flg_wa = cidx; nxt_wa = cidx;
        ver_wd = ver_rd; flg_wd = flg_rd; nxt_wd = '0;
        q_wa = q_tail; q_wd = '0;
        n_status = vha_pkg::ST_OK; n_id = '0; n_ver = '0;
        n_ev = vha_pkg::EV_NONE; n_valid = 1'b0;
        hold = 1'b0;
        if (fire) begin
            unique case (vha_pkg::t_op'(r_op))
                vha_pkg::OP_CREATE: begin
                    if (q_full) begin
                        n_status = vha_pkg::ST_QFULL;
                    end else if (r_fempty && r_in_use >= (SW+1)'(TABLE_ENTRIES)) begin
                        n_status = vha_pkg::ST_FULL;
                    end else begin
                        if (r_fempty) begin
                            ver_wa = r_in_use[SW-1:0];
                            ver_we = 1'b1; ver_wd = '0;
                            n_id = vha_pkg::IdW'(r_in_use) + 1'b1;
                            n_ver = '0;
                        end else begin
                            ver_wa = r_fhead;
                            n_id = vha_pkg::IdW'(r_fhead) + 1'b1;
                            n_ver = vha_pkg::VerW'(ver_rd);
                        end
                        flg_wa = ver_wa; nxt_wa = ver_wa;
                        flg_we = 1'b1; flg_wd = F_VALID;
                        nxt_we = 1'b1;
                        q_we = 1'b1;
                        q_wd = {vha_pkg::KIND_CREATE, ver_wa, VB'(n_ver)};
                    end
                end
                vha_pkg::OP_DESTROY: begin
                    n_id = r_hid; n_ver = r_hver;
                    if (!live_ok) begin
                        n_status = vha_pkg::ST_INVALID;
                    end else if (q_full) begin
                        n_status = vha_pkg::ST_QFULL;
                    end else begin
                        flg_wa = hidx; flg_we = 1'b1; flg_wd = flg_rd | F_DESTROY;
                        q_we = 1'b1;
                        q_wd = {vha_pkg::KIND_DESTROY, hidx, ver_rd};
                    end
                end
                vha_pkg::OP_PROCESS: begin
                    if (r_qcount == '0) begin
                        n_status = vha_pkg::ST_QEMPTY;
                    end else begin
                        n_id = vha_pkg::IdW'(cidx) + 1'b1;
                        n_ver = vha_pkg::VerW'(cver);
                        if ((SW+1)'(cidx) >= r_in_use || !flg_rd[0] || ver_rd != cver) begin
                            n_status = vha_pkg::ST_STALE;
                        end else if (ckind == vha_pkg::KIND_CREATE) begin
                            if (r_fin) begin
                                flg_we = 1'b1; flg_wd = flg_rd | F_FINAL;
                                n_ev = vha_pkg::EV_FINAL;
                            end else begin
                                if (!flg_rd[1]) begin
                                    flg_we = 1'b1; flg_wd = flg_rd | F_DESTROY;
                                    q_we = 1'b1;
                                    q_wd = {vha_pkg::KIND_DESTROY, cidx, cver};
                                end
                                n_ev = vha_pkg::EV_FAILED;
                            end
                        end else begin
                            flg_we = 1'b1; flg_wd = '0;
                            ver_we = 1'b1; ver_wd = VB'(ver_rd + 1'b1);
                            nxt_wa = r_ftail; nxt_wd = cidx; nxt_we = !r_fempty;
                            n_ev = vha_pkg::EV_DESTROYED;
                        end
                    end
                end
                default: begin
                    n_id = r_hid; n_ver = r_hver; n_valid = live_ok;
                end
            endcase
        end else begin
            hold = i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_hid <= i_hid; r_hver <= i_hver; r_fin <= i_fin_ok;
        end
        if (fire) begin
            o_status <= n_status; o_id <= n_id; o_ver <= n_ver;
            o_ev <= n_ev; o_valid <= n_valid;
        end
    end

    logic p_ok;
    assign p_ok = fire && vha_pkg::t_op'(r_op) == vha_pkg::OP_PROCESS && r_qcount != '0
               && n_status == vha_pkg::ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0; r_fhead <= '0; r_ftail <= '0; r_fempty <= 1'b1;
            r_qhead <= '0; r_qcount <= '0; r_live <= '0;
            o_out_valid <= 1'b0; r_phase <= 1'b0;
        end else begin
            r_phase <= hold;
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            if (fire) o_out_valid <= 1'b1;
            if (fire && vha_pkg::t_op'(r_op) == vha_pkg::OP_CREATE && q_we) begin
                if (r_fempty) r_in_use <= r_in_use + 1'b1;
                else if (r_fhead == r_ftail) r_fempty <= 1'b1;
                else r_fhead <= nxt_rd;
            end
            if (p_ok && ckind == vha_pkg::KIND_CREATE && r_fin && !flg_rd[2])
                r_live <= r_live + 1'b1;
            if (p_ok && ckind == vha_pkg::KIND_DESTROY) begin
                if (flg_rd[2] && r_live != '0) r_live <= r_live - 1'b1;
                r_ftail <= cidx;
                if (r_fempty) begin
                    r_fhead <= cidx; r_fempty <= 1'b0;
                end
            end
            if (fire && vha_pkg::t_op'(r_op) == vha_pkg::OP_PROCESS && r_qcount != '0) begin
                r_qhead <= QW'(r_qhead + 1'b1);
                r_qcount <= r_qcount - 1'b1 + (QW+1)'(q_we);
            end else if (q_we) begin
                r_qcount <= r_qcount + 1'b1;
            end
        end
    end

    // a re-queued destroy lands at old head plus old count, the tail after the pop
    assign o_active = vha_pkg::IdW'(r_live);

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (r_qcount <= (QW+1)'(QUEUE_DEPTH))
                else $error("queue count overflow");
            assert (r_in_use <= (SW+1)'(TABLE_ENTRIES))
                else $error("slot count overflow");
        end
    end

    a_fire_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> i_cmd.exec) else $error("fire outside execute");
    a_out_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid) else $error("result not presented");
    a_live_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_in_use) else $error("live count exceeds slots");
endmodule
`default_nettype wire

[sv/versioned_handle_allocator.sv]
// Top level of the versioned handle allocator: controller plus datapath.
// Depends on vha_pkg, vha_ctrl, vha_dp, vha_ram.
//  channel | dir | tdata fields (low bit up)                            | tuser
//  s_axis  | in  | handle_id[8:0], handle_version[24:9], finalize_ok[25] | op[1:0]
//  m_axis  | out | status[2:0], out_id[11:3], out_version[27:12],       | -
//          |     | event_res[29:28], is_valid[30], active_count[39:31]  |
// A result is registered when its request executes; a process beat that finds the
// queue non-empty first waits for the queue entry, then for the slot read.
// One request is in flight; the next beat can be accepted at the edge its result is taken.
// Reset clears counters, pointers, state and output valid; memories are not cleared.
// A held result stalls input acceptance until m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none
module versioned_handle_allocator #(
    parameter int TABLE_ENTRIES = vha_pkg::TableEntries,
    parameter int QUEUE_DEPTH   = vha_pkg::QueueDepth,
    parameter int VERSION_BITS  = vha_pkg::VersionBits
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // handle_id, handle_version, finalize_ok
    input  wire logic [1:0]  s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // status, out_id, out_version, event_res,
                                            // is_valid, active_count
);
    vha_pkg::t_cmd cmd;
    vha_pkg::t_sts sts;
    logic [2:0]  st;
    logic [8:0]  oid, act;
    logic [15:0] over;
    logic [1:0]  ev;
    logic        vld;

    vha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_out_free(!m_axis_tvalid || m_axis_tready), .i_sts(sts), .o_cmd(cmd));

    vha_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .QUEUE_DEPTH(QUEUE_DEPTH),
             .VERSION_BITS(VERSION_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts), .i_op(s_axis_tuser),
        .i_hid(s_axis_tdata[8:0]), .i_hver(s_axis_tdata[24:9]),
        .i_fin_ok(s_axis_tdata[25]),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_status(st), .o_id(oid), .o_ver(over), .o_ev(ev), .o_valid(vld),
        .o_active(act));

    assign m_axis_tdata = {act, vld, ev, over, oid, st};
endmodule
`default_nettype wire
